### hdl/ppbt_pkg.sv
// Package for the packet pacer: word types, register indexes, codes and reset values.
// Used by every module of the pacer; depends on nothing.
package ppbt_pkg;

    // Field widths
    localparam int TIME_W  = 48;
    localparam int RATE_W  = 40;
    localparam int BIF_W   = 32;
    localparam int PKT_W   = 16;
    localparam int CWND_W  = 32;
    localparam int BURST_W = 8;
    localparam int SEG_W   = 16;
    localparam int GRAN_W  = 20;
    localparam int CFG_W   = 40;
    localparam int CFG_IDX_W = 8;

    // Internal time width default and divider width
    localparam int TIME_BITS_DEFAULT = 48;
    localparam int DIV_BITS = 40;

    // Bytes to bits, seconds to microseconds
    localparam logic [23:0] BIT_US_SCALE = 24'd8000000;

    // Request codes
    localparam logic [1:0] FUNC_SENT  = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CONG  = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAN     = 8'd3;

    // Reset values
    localparam logic [RATE_W-1:0]  MAX_RATE_RESET = '0;
    localparam logic [BURST_W-1:0] BURST_RESET    = 8'd10;
    localparam logic [SEG_W-1:0]   SEGMENT_RESET  = 16'd1460;
    localparam logic [GRAN_W-1:0]  GRAN_RESET     = 20'd1000;
    localparam logic [BURST_W-1:0] TOKENS_RESET   = 8'd10;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]        func;
        logic [TIME_W-1:0] time_us;
        logic [BIF_W-1:0]  inflight_bytes;
        logic [PKT_W-1:0]  packet_bytes;
        logic [CWND_W-1:0] cwnd_bytes;
        logic              in_recovery;
        logic [RATE_W-1:0] underlying_rate_bps;
        logic              underlying_blocked;
        logic              has_losses;
    } req_word_t;

    typedef struct packed {
        logic [TIME_W-1:0] wait_us;
        logic              wait_forever;
    } rsp_word_t;

    typedef struct packed {
        logic [RATE_W-1:0]  max_rate_bps;
        logic [BURST_W-1:0] initial_burst;
        logic [SEG_W-1:0]   segment_bytes;
        logic [GRAN_W-1:0]  alarm_granularity_us;
    } cfg_t;

    // Classified command as queued between front and back
    typedef struct packed {
        logic [1:0]        op;
        logic [TIME_W-1:0] time_us;
        logic              refill;
        logic              bif_zero;
        logic [PKT_W-1:0]  packet_bytes;
        logic [CWND_W-1:0] cwnd_bytes;
        logic [RATE_W-1:0] rate;
        logic              blocked;
        logic              has_losses;
    } cmd_t;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [DIV_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

### hdl/ppbt_front.sv
// Front end of the pacer: accepts request words, classifies them and queues commands.
// Depends on ppbt_pkg.
module ppbt_front (
    input  logic               req_valid,
    output logic               req_ready,
    input  ppbt_pkg::req_word_t req_word,
    input  ppbt_pkg::cfg_t     cfg,
    output logic               push,
    output ppbt_pkg::cmd_t     push_word,
    input  logic               queue_full
);
    import ppbt_pkg::*;

    logic rate_capped;

    // Take a word whenever the queue has room
    assign req_ready = ~queue_full;

    // Drop the unused code, queue everything else
    assign push = req_valid & ~queue_full & (req_word.func != FUNC_NONE);

    // Apply the rate cap when one is set
    assign rate_capped = (cfg.max_rate_bps != '0) &&
                         (cfg.max_rate_bps < req_word.underlying_rate_bps);

    always_comb
    begin
        push_word.op           = req_word.func;
        push_word.time_us      = req_word.time_us;
        push_word.bif_zero     = (req_word.inflight_bytes == '0);
        push_word.refill       = (req_word.inflight_bytes == '0) & ~req_word.in_recovery;
        push_word.packet_bytes = req_word.packet_bytes;
        push_word.cwnd_bytes   = req_word.cwnd_bytes;
        push_word.rate         = rate_capped ? cfg.max_rate_bps
                                             : req_word.underlying_rate_bps;
        push_word.blocked      = req_word.underlying_blocked;
        push_word.has_losses   = req_word.has_losses;
    end

endmodule

### hdl/ppbt_fifo.sv
// Short command queue between the pacer front end and back end.
// Depends on ppbt_pkg for the command type and depth.
module ppbt_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ppbt_pkg::cmd_t push_word,
    output logic           full,
    output logic           head_valid,
    output ppbt_pkg::cmd_t head,
    input  logic           pop
);
    import ppbt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

### hdl/ppbt_div.sv
// Restoring divider for the pacer, one quotient bit per cycle.
// Depends on ppbt_pkg for the divider width and request/response types.
module ppbt_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ppbt_pkg::div_req_t div_req,
    output ppbt_pkg::div_rsp_t div_rsp
);
    import ppbt_pkg::*;

    localparam int CNT_W = $clog2(DIV_BITS + 1);

    logic                busy_reg, done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DIV_BITS-1:0] rem_reg, quo_reg, dvs_reg;
    logic [DIV_BITS:0]   shifted, diff;
    logic                fits;

    // Trial subtract of the divisor from the shifted remainder
    assign shifted = {rem_reg, quo_reg[DIV_BITS-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (div_req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Shift in one quotient bit per step
    always_ff @(posedge clk)
    begin
        if (div_req.start)
        begin
            rem_reg <= '0;
            quo_reg <= div_req.dividend;
            dvs_reg <= div_req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
            quo_reg <= {quo_reg[DIV_BITS-2:0], fits};
        end
    end

endmodule

### hdl/ppbt_back.sv
// Back end of the pacer: token and schedule state, delay sequencing, query answers.
// Depends on ppbt_pkg; drives the shared divider ppbt_div.
module ppbt_back #(
    parameter int TIME_BITS = ppbt_pkg::TIME_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ppbt_pkg::cfg_t      cfg,
    input  logic                head_valid,
    input  ppbt_pkg::cmd_t      head,
    output logic                head_pop,
    output ppbt_pkg::div_req_t  div_req,
    input  ppbt_pkg::div_rsp_t  div_rsp,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ppbt_pkg::rsp_word_t rsp_word
);
    import ppbt_pkg::*;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam int SUM_W   = ((TIME_BITS > DIV_BITS) ? TIME_BITS : DIV_BITS) + 1;
    localparam int CLAMP_W = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_REFILL  = 4'd1;
    localparam logic [3:0] ST_REFWAIT = 4'd2;
    localparam logic [3:0] ST_TOKEN   = 4'd3;
    localparam logic [3:0] ST_DELAY   = 4'd4;
    localparam logic [3:0] ST_DELWAIT = 4'd5;
    localparam logic [3:0] ST_SUM     = 4'd6;
    localparam logic [3:0] ST_UPDATE  = 4'd7;
    localparam logic [3:0] ST_QSUM    = 4'd8;
    localparam logic [3:0] ST_QOUT    = 4'd9;

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [DIV_BITS-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s > SUM_W'(TIME_MAX))
            sat_add = TIME_MAX;
        else
            sat_add = s[TIME_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] clamp_time(input logic [TIME_W-1:0] t);
        logic [CLAMP_W-1:0] w;
        w = CLAMP_W'(t);
        if (w > CLAMP_W'(TIME_MAX))
            clamp_time = TIME_MAX;
        else
            clamp_time = w[TIME_BITS-1:0];
    endfunction

    // Control state
    logic [3:0]           state_reg, state_next;
    logic [BURST_W-1:0]   tokens_reg, tokens_next;
    logic [TIME_BITS-1:0] ideal_reg, ideal_next;
    logic [TIME_BITS-1:0] ldst_reg, ldst_next;
    logic                 delayed_reg, delayed_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    // Working payload
    cmd_t                 cmd_reg, cmd_next;
    logic [TIME_BITS-1:0] t_reg, t_next;
    logic [DIV_BITS-1:0]  prod_reg, prod_next;
    logic [DIV_BITS-1:0]  delay_reg, delay_next;
    logic [TIME_BITS-1:0] sum_ideal_reg, sum_ideal_next;
    logic [TIME_BITS-1:0] sum_t_reg, sum_t_next;
    logic [TIME_BITS-1:0] sum_ldst_reg, sum_ldst_next;
    logic [TIME_BITS-1:0] thresh_reg, thresh_next;
    rsp_word_t            rsp_word_reg, rsp_word_next;

    logic app_limited, catching_up;

    // Catch-up rules for a send that follows a delayed one
    assign app_limited = (ldst_reg != '0) && (t_reg > sum_ldst_reg);
    assign catching_up = (sum_ideal_reg <= t_reg);

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    always_comb
    begin
        state_next     = state_reg;
        tokens_next    = tokens_reg;
        ideal_next     = ideal_reg;
        ldst_next      = ldst_reg;
        delayed_next   = delayed_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp_ready;
        cmd_next       = cmd_reg;
        t_next         = t_reg;
        prod_next      = prod_reg;
        delay_next     = delay_reg;
        sum_ideal_next = sum_ideal_reg;
        sum_t_next     = sum_t_reg;
        sum_ldst_next  = sum_ldst_reg;
        thresh_next    = thresh_reg;
        rsp_word_next  = rsp_word_reg;
        head_pop         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = cmd_reg.rate;

        unique case (state_reg)
            // Take the next queued command
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    head_pop = 1'b1;
                    cmd_next = head;
                    t_next   = clamp_time(head.time_us);
                    case (head.op)
                        FUNC_SENT:  state_next = ST_REFILL;
                        FUNC_QUERY: state_next = ST_QSUM;
                        default:
                        begin
                            if (head.has_losses)
                            begin
                                tokens_next = '0;
                            end
                        end
                    endcase
                end
            end
            // Refill burst tokens when leaving quiescence
            ST_REFILL:
            begin
                state_next = ST_TOKEN;
                if (cmd_reg.refill)
                begin
                    if (cfg.segment_bytes == '0)
                    begin
                        tokens_next = cfg.initial_burst;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_BITS'(cmd_reg.cwnd_bytes);
                        div_req.divisor  = DIV_BITS'(cfg.segment_bytes);
                        state_next       = ST_REFWAIT;
                    end
                end
            end
            ST_REFWAIT:
            begin
                if (div_rsp.done)
                begin
                    tokens_next = (div_rsp.quotient < DIV_BITS'(cfg.initial_burst))
                                ? div_rsp.quotient[BURST_W-1:0] : cfg.initial_burst;
                    state_next  = ST_TOKEN;
                end
            end
            // Spend a token, or scale the packet size for the delay
            ST_TOKEN:
            begin
                if (tokens_reg != '0)
                begin
                    tokens_next  = tokens_reg - 1'b1;
                    delayed_next = 1'b0;
                    ldst_next    = '0;
                    ideal_next   = '0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    prod_next  = DIV_BITS'(DIV_BITS'(cmd_reg.packet_bytes) *
                                           DIV_BITS'(BIT_US_SCALE));
                    state_next = ST_DELAY;
                end
            end
            ST_DELAY:
            begin
                if (cmd_reg.rate == '0)
                begin
                    delay_next = '0;
                    state_next = ST_SUM;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DELWAIT;
                end
            end
            ST_DELWAIT:
            begin
                if (div_rsp.done)
                begin
                    delay_next = div_rsp.quotient;
                    state_next = ST_SUM;
                end
            end
            // Form the saturated schedule sums
            ST_SUM:
            begin
                sum_ideal_next = sat_add(ideal_reg, delay_reg);
                sum_t_next     = sat_add(t_reg, delay_reg);
                sum_ldst_next  = sat_add(ldst_reg, delay_reg);
                state_next     = ST_UPDATE;
            end
            // Commit the next ideal send time
            ST_UPDATE:
            begin
                if (delayed_reg)
                begin
                    ideal_next = sum_ideal_reg;
                    if (catching_up && !app_limited)
                    begin
                        ldst_next = t_reg;
                    end
                    else
                    begin
                        delayed_next = 1'b0;
                        ldst_next    = '0;
                    end
                end
                else
                begin
                    ideal_next = (sum_ideal_reg > sum_t_reg) ? sum_ideal_reg : sum_t_reg;
                end
                state_next = ST_IDLE;
            end
            ST_QSUM:
            begin
                thresh_next = sat_add(t_reg, DIV_BITS'(cfg.alarm_granularity_us));
                state_next  = ST_QOUT;
            end
            // Answer the query once the output register is free
            ST_QOUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_word_next.wait_us      = '0;
                    rsp_word_next.wait_forever = 1'b0;
                    if (cmd_reg.blocked)
                    begin
                        rsp_word_next.wait_forever = 1'b1;
                    end
                    else if ((tokens_reg == '0) && !cmd_reg.bif_zero &&
                             (ideal_reg > thresh_reg))
                    begin
                        delayed_next          = 1'b1;
                        rsp_word_next.wait_us = TIME_W'(ideal_reg - t_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tokens_reg    <= TOKENS_RESET;
            ideal_reg     <= '0;
            ldst_reg      <= '0;
            delayed_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tokens_reg    <= tokens_next;
            ideal_reg     <= ideal_next;
            ldst_reg      <= ldst_next;
            delayed_reg   <= delayed_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        t_reg         <= t_next;
        prod_reg      <= prod_next;
        delay_reg     <= delay_next;
        sum_ideal_reg <= sum_ideal_next;
        sum_t_reg     <= sum_t_next;
        sum_ldst_reg  <= sum_ldst_next;
        thresh_reg    <= thresh_next;
        rsp_word_reg  <= rsp_word_next;
    end

endmodule

### hdl/packet_pacer_burst_tokens.sv
// Top level of the packet pacer with burst tokens: configuration registers and wiring.
// Depends on ppbt_pkg, ppbt_front, ppbt_fifo, ppbt_back and ppbt_div.
//
// Usage: request words arrive on req_valid/req_ready/req_word. A sent word updates
// the burst tokens and pacing schedule, a congestion word may clear the tokens, a
// query word returns one response word on rsp_valid/rsp_ready/rsp_word with the
// wait in microseconds, or wait_forever when the controller blocks. Code 3 is dropped.
// A two-entry command queue sits between the front end and the back end, so the
// front keeps taking words while the back works or a response waits to be taken.
// Words are carried out one at a time by the back end: a congestion word is handled
// as it is taken; a query word passes through the threshold sum to the response register;
// a sent word first refills the tokens when due, then spends a token, or without a token
// divides for the delay, then forms and commits the schedule sums. Both divides, the
// window refill and the delay, use the shared restoring divider.
// A stalled receiver holds the response register; the back end then waits at the
// next query and the queue fills, after which req_ready drops.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user must do so
// only while idle, as the block does not enforce it. Reset: registers return to their
// defaults, tokens to 10, schedule to zero, queue empty; no clearing pass is needed.
module packet_pacer_burst_tokens #(
    parameter int TIME_BITS = ppbt_pkg::TIME_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  ppbt_pkg::req_word_t                  req_word,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output ppbt_pkg::rsp_word_t                  rsp_word,
    input  logic                                 cfg_wr_en,
    input  logic [ppbt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppbt_pkg::CFG_W-1:0]           cfg_wdata
);
    import ppbt_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    logic     push, queue_full, head_valid, head_pop;
    cmd_t     push_word, head;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MAX_RATE: cfg_next.max_rate_bps         = cfg_wdata[RATE_W-1:0];
                CFG_BURST:    cfg_next.initial_burst        = cfg_wdata[BURST_W-1:0];
                CFG_SEGMENT:  cfg_next.segment_bytes        = cfg_wdata[SEG_W-1:0];
                CFG_GRAN:     cfg_next.alarm_granularity_us = cfg_wdata[GRAN_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_rate_bps         <= MAX_RATE_RESET;
            cfg_reg.initial_burst        <= BURST_RESET;
            cfg_reg.segment_bytes        <= SEGMENT_RESET;
            cfg_reg.alarm_granularity_us <= GRAN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ppbt_front u_front (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_word   (req_word),
        .cfg        (cfg_reg),
        .push       (push),
        .push_word  (push_word),
        .queue_full (queue_full)
    );

    ppbt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (push_word),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (head_pop)
    );

    ppbt_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_word   (rsp_word)
    );

    ppbt_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

endmodule

### verif/ppbt_checker.sv
// Checker for the packet pacer: watches the request, response and register ports,
// predicts each query's wait and compares it with the response word. Depends on ppbt_pkg.
module ppbt_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_ready,
    input  ppbt_pkg::req_word_t            req_word,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  ppbt_pkg::rsp_word_t            rsp_word,
    input  logic                           cfg_wr_en,
    input  logic [ppbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppbt_pkg::CFG_W-1:0]     cfg_wdata,
    output int                             fail_count,
    output int                             outstanding
);
    import ppbt_pkg::*;

    localparam logic [63:0] TIME_LIMIT = (64'd1 << TIME_W) - 64'd1;

    // Mirror of the pacer registers
    logic [RATE_W-1:0]  max_rate;
    logic [BURST_W-1:0] burst_limit;
    logic [SEG_W-1:0]   segment;
    logic [GRAN_W-1:0]  granularity;

    // Mirror of the pacing schedule
    logic [BURST_W-1:0] tokens;
    logic [TIME_W-1:0]  last_delayed_at;
    logic [TIME_W-1:0]  ideal_next;
    logic               was_delayed;

    rsp_word_t expected_waits[$];
    int        fails;

    // Add a delay to a time, saturating at the top of the time range
    function automatic logic [TIME_W-1:0] time_sum(input logic [TIME_W-1:0] a,
                                                  input logic [63:0] b);
        logic [64:0] s;
        s = {17'd0, a} + {1'b0, b};
        if (s > {1'b0, TIME_LIMIT})
            return TIME_LIMIT[TIME_W-1:0];
        return s[TIME_W-1:0];
    endfunction

    // Advance the schedule by one request word; queue the wait for a query
    task automatic pace_step(input req_word_t w);
        logic [63:0]       refill;
        logic [63:0]       quotient;
        logic [RATE_W-1:0] rate;
        logic [63:0]       delay;
        logic [TIME_W-1:0] via_ideal;
        logic [TIME_W-1:0] via_now;
        logic              app_limited;
        logic              catching_up;
        rsp_word_t         answer;
        case (w.func)
            FUNC_SENT:
            begin
                if (w.inflight_bytes == '0 && !w.in_recovery)
                begin
                    refill = 64'(burst_limit);
                    if (segment != '0)
                    begin
                        quotient = 64'(w.cwnd_bytes) / 64'(segment);
                        if (quotient < refill)
                            refill = quotient;
                    end
                    tokens = refill[BURST_W-1:0];
                end
                if (tokens != '0)
                begin
                    tokens = tokens - 1'b1;
                    was_delayed = 1'b0;
                    last_delayed_at = '0;
                    ideal_next = '0;
                end
                else
                begin
                    rate = w.underlying_rate_bps;
                    if (max_rate != '0 && max_rate < rate)
                        rate = max_rate;
                    delay = '0;
                    if (rate != '0)
                        delay = (64'(w.packet_bytes) * 64'(BIT_US_SCALE)) / 64'(rate);
                    if (was_delayed)
                    begin
                        ideal_next = time_sum(ideal_next, delay);
                        app_limited = (last_delayed_at != '0) &&
                                      (w.time_us > time_sum(last_delayed_at, delay));
                        catching_up = (ideal_next <= w.time_us);
                        if (catching_up && !app_limited)
                            last_delayed_at = w.time_us;
                        else
                        begin
                            was_delayed = 1'b0;
                            last_delayed_at = '0;
                        end
                    end
                    else
                    begin
                        via_ideal = time_sum(ideal_next, delay);
                        via_now = time_sum(w.time_us, delay);
                        ideal_next = (via_ideal > via_now) ? via_ideal : via_now;
                    end
                end
            end
            FUNC_QUERY:
            begin
                answer = '0;
                if (w.underlying_blocked)
                    answer.wait_forever = 1'b1;
                else if (tokens == '0 && w.inflight_bytes != '0 &&
                         ideal_next > time_sum(w.time_us, 64'(granularity)))
                begin
                    was_delayed = 1'b1;
                    answer.wait_us = ideal_next - w.time_us;
                end
                expected_waits.push_back(answer);
            end
            FUNC_CONG:
            begin
                if (w.has_losses)
                    tokens = '0;
            end
            default:
            begin
                // drop the unused code
            end
        endcase
    endtask

    // Track registers, compare responses, predict accepted requests
    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t want;
        if (!rst_n)
        begin
            max_rate = MAX_RATE_RESET;
            burst_limit = BURST_RESET;
            segment = SEGMENT_RESET;
            granularity = GRAN_RESET;
            tokens = TOKENS_RESET;
            last_delayed_at = '0;
            ideal_next = '0;
            was_delayed = 1'b0;
            expected_waits.delete();
            fails = 0;
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MAX_RATE: max_rate = cfg_wdata[RATE_W-1:0];
                    CFG_BURST:    burst_limit = cfg_wdata[BURST_W-1:0];
                    CFG_SEGMENT:  segment = cfg_wdata[SEG_W-1:0];
                    CFG_GRAN:     granularity = cfg_wdata[GRAN_W-1:0];
                    default:      ;
                endcase
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_waits.size() == 0)
                begin
                    $error("response word with no query waiting: wait_us %0d, wait_forever %0d",
                           rsp_word.wait_us, rsp_word.wait_forever);
                    fails++;
                end
                else
                begin
                    want = expected_waits.pop_front();
                    if (rsp_word.wait_us !== want.wait_us)
                    begin
                        $error("wait_us: expected %0d, got %0d", want.wait_us, rsp_word.wait_us);
                        fails++;
                    end
                    if (rsp_word.wait_forever !== want.wait_forever)
                    begin
                        $error("wait_forever: expected %0d, got %0d",
                               want.wait_forever, rsp_word.wait_forever);
                        fails++;
                    end
                end
            end
            if (req_valid && req_ready)
                pace_step(req_word);
            fail_count <= fails;
            outstanding <= expected_waits.size();
        end
    end

endmodule

### verif/testbench.sv
// Top of the packet pacer testbench: clock, reset, request and register stimulus,
// response stalls and the verdict. Depends on ppbt_pkg, ppbt_checker and the pacer RTL.
module testbench;
    import ppbt_pkg::*;

    localparam int PHASES          = 6;
    localparam int PHASE_WORDS     = 316;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int SETTLE_CYCLES   = 400;
    localparam logic [TIME_W-1:0] TIME_TOP = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    req_word_t            req_word;
    logic                 rsp_valid;
    logic                 rsp_ready;
    rsp_word_t            rsp_word;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    int                   fail_count;
    int                   outstanding;

    int                   snd_idle_pct;
    int                   rcv_stall_pct;
    bit                   hold_off_req;
    logic [TIME_W-1:0]    flow_now;

    packet_pacer_burst_tokens u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ppbt_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_word    (req_word),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_word    (rsp_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Hard stop if the run hangs
    initial
    begin
        #40000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic req_word_t make_word(input logic [1:0] func,
                                            input logic [TIME_W-1:0] t,
                                            input logic [BIF_W-1:0] bif,
                                            input logic [PKT_W-1:0] pkt,
                                            input logic [CWND_W-1:0] cwnd,
                                            input logic recov,
                                            input logic [RATE_W-1:0] rate,
                                            input logic blocked,
                                            input logic losses);
        req_word_t w;
        w.func = func;
        w.time_us = t;
        w.inflight_bytes = bif;
        w.packet_bytes = pkt;
        w.cwnd_bytes = cwnd;
        w.in_recovery = recov;
        w.underlying_rate_bps = rate;
        w.underlying_blocked = blocked;
        w.has_losses = losses;
        return w;
    endfunction

    function automatic req_word_t noise_word();
        logic [191:0] bits;
        req_word_t    w;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        w = bits[$bits(req_word_t)-1:0];
        return w;
    endfunction

    // Build one word of a plausible traffic flow, or a noise word now and then
    task automatic flow_word(output req_word_t w);
        int pick;
        w = noise_word();
        pick = $urandom_range(0, 99);
        if (pick >= 12)
        begin
            if ($urandom_range(0, 19) == 0)
                flow_now = flow_now + TIME_W'($urandom_range(0, 100000));
            else
                flow_now = flow_now + TIME_W'($urandom_range(0, 2500));
            w.time_us = flow_now;
            w.inflight_bytes = ($urandom_range(0, 9) == 0) ? '0 :
                               BIF_W'($urandom_range(1, 100000));
            w.in_recovery = ($urandom_range(0, 4) == 0);
            w.underlying_blocked = ($urandom_range(0, 9) == 0);
            if (pick < 60)
            begin
                w.func = FUNC_SENT;
                w.packet_bytes = PKT_W'($urandom_range(1000, 1500));
                w.cwnd_bytes = CWND_W'(1460 * $urandom_range(0, 40));
                w.underlying_rate_bps = ($urandom_range(0, 19) == 0) ? '0 :
                                        RATE_W'($urandom_range(100000, 50000000));
            end
            else if (pick < 90)
                w.func = FUNC_QUERY;
            else
                w.func = FUNC_CONG;
        end
    endtask

    // Offer one word, idling first at the current rate, and hold it until taken
    task automatic push_word(input req_word_t w);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word <= w;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Response side: random stalls, plus one long hold-off on request
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    // Stimulus and verdict
    initial
    begin
        req_word_t            w;
        req_word_t            opening[$];
        logic [CFG_W-1:0]     reg_value[4];
        logic [CFG_IDX_W-1:0] reg_index[4];

        req_valid = 1'b0;
        req_word = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MAX_RATE;
        cfg_wdata = '0;
        rst_n = 1'b0;
        snd_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_off_req = 1'b0;
        flow_now = '0;
        reg_index = '{CFG_MAX_RATE, CFG_BURST, CFG_SEGMENT, CFG_GRAN};

        // Directed words under the reset settings
        opening.push_back(make_word(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
        opening.push_back(make_word(FUNC_QUERY, 100, 5000, 0, 0, 0, 0, 1, 0));
        opening.push_back('1);
        opening.push_back(make_word(FUNC_SENT, 200, 0, 1460, 5840, 0, 1000000, 0, 0));
        opening.push_back(make_word(FUNC_CONG, 300, 0, 0, 0, 0, 0, 0, 0));
        opening.push_back(make_word(FUNC_QUERY, 400, 5000, 0, 0, 0, 0, 0, 0));
        opening.push_back(make_word(FUNC_CONG, 500, 0, 0, 0, 0, 0, 0, 1));
        opening.push_back(make_word(FUNC_SENT, 600, 5000, 1500, 0, 0, 0, 0, 0));
        opening.push_back(make_word(FUNC_SENT, 700, 5000, 1500, 0, 0, 1000000, 0, 0));
        opening.push_back(make_word(FUNC_QUERY, 800, 5000, 0, 0, 0, 0, 0, 0));
        opening.push_back(make_word(FUNC_SENT, 12700, 5000, 1500, 0, 0, 1000000, 0, 0));
        opening.push_back(make_word(FUNC_QUERY, 13000, 5000, 0, 0, 0, 0, 0, 0));
        opening.push_back(make_word(FUNC_SENT, 40000, 5000, 1500, 0, 0, 1000000, 0, 0));
        opening.push_back(make_word(FUNC_QUERY, 40000, 5000, 0, 0, 0, 0, 0, 0));
        opening.push_back(make_word(FUNC_SENT, 60000, 5000, 1500, 0, 0, 1000000, 0, 0));
        opening.push_back(make_word(FUNC_SENT, 60100, 5000, '1, 0, 0, '1, 0, 0));
        opening.push_back(make_word(FUNC_SENT, 60200, 5000, 0, 0, 0, 1000000, 0, 0));
        opening.push_back(make_word(FUNC_SENT, TIME_TOP - 5, 5000, '1, 0, 0, 1, 0, 0));
        opening.push_back(make_word(FUNC_QUERY, TIME_TOP, '1, 0, 0, 0, 0, 0, 0));
        opening.push_back(make_word(FUNC_SENT, 70000, 0, 1460, 14600, 1, 1000000, 0, 0));
        opening.push_back(make_word(FUNC_SENT, 70100, 0, 1460, '1, 0, 1000000, 0, 0));
        opening.push_back(make_word(FUNC_SENT, 70200, 0, 1460, 0, 0, 1000000, 0, 0));
        opening.push_back(make_word(FUNC_QUERY, 70300, '1, 0, 0, 0, 0, 0, 0));
        opening.push_back(make_word(FUNC_SENT, '1, '1, '1, '1, 1, '1, 1, 1));
        opening.push_back(make_word(FUNC_CONG, '1, '1, '1, '1, 1, '1, 1, 1));
        opening.push_back(make_word(FUNC_QUERY, 0, 1, 0, 0, 0, 0, 0, 0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // Drain, let silent words finish, then load the next settings
            if (phase != 0)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0) @(posedge clk);
                repeat (SETTLE_CYCLES) @(posedge clk);
                case (phase)
                    1: reg_value = '{'1, 255, 1, 1000000};
                    2: reg_value = '{0, 0, 65535, 0};
                    4: reg_value = '{1, 3, 0, 20'hFFFFF};
                    default:
                        reg_value = '{CFG_W'($urandom_range(1000000, 100000000)),
                                      CFG_W'($urandom_range(0, 20)),
                                      CFG_W'($urandom_range(500, 9000)),
                                      CFG_W'($urandom_range(0, 3000))};
                endcase
                for (int i = 0; i < 4; i++)
                begin
                    cfg_wr_en <= 1'b1;
                    cfg_index <= reg_index[i];
                    cfg_wdata <= reg_value[i];
                    @(posedge clk);
                end
                cfg_wr_en <= 1'b0;
            end

            case (phase % 4)
                0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1:       begin snd_idle_pct = 68; rcv_stall_pct = 0;  end
                2:       begin snd_idle_pct = 0;  rcv_stall_pct = 68; end
                default: begin snd_idle_pct = 12; rcv_stall_pct = 12; end
            endcase
            hold_off_req = (phase == 2);
            flow_now = (phase == 1) ? TIME_TOP - 3000000 : TIME_W'({$urandom, $urandom});

            if (phase == 0)
                foreach (opening[i])
                    push_word(opening[i]);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                flow_word(w);
                push_word(w);
            end
        end

        // Drain and settle before the verdict
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### packet_pacer_burst_tokens.f
hdl/ppbt_pkg.sv
hdl/ppbt_front.sv
hdl/ppbt_fifo.sv
hdl/ppbt_div.sv
hdl/ppbt_back.sv
hdl/packet_pacer_burst_tokens.sv
verif/ppbt_checker.sv
verif/testbench.sv
